### sv/gcsa_pkg.sv
// Shared types, constants and tables of the corner shadow alpha block.
package gcsa_pkg;

	localparam int MAX_SIZE_DEF = 1024;

	localparam int REG_W    = 11;
	localparam int COORD_W  = 10;
	localparam int ALPHA_W  = 8;
	localparam int RAD_W    = 38;   // radicand (col^2 + row^2) << 16
	localparam int ROOT_W   = 19;   // distance, unsigned 11.8
	localparam int NUM_W    = 41;   // dividend of the exponent division
	localparam int DEN_W    = 22;   // (size - radius)^2
	localparam int Q_W      = 19;   // exponent, Q16 with 3 integer bits
	localparam int M_W      = 17;   // mantissa, Q16, at most 1.0
	localparam int FRAC_W   = 16;

	localparam logic [REG_W-1:0] TEX_SIZE_RST      = REG_W'(64);
	localparam logic [REG_W-1:0] CORNER_RADIUS_RST = '0;
	localparam logic [Q_W-1:0]   LOG2_255_Q16      = Q_W'(523918);

	typedef enum logic {
		REG_TEX_SIZE      = 1'b0,
		REG_CORNER_RADIUS = 1'b1
	} reg_idx_t;

	// what an item turns into, settled as early as possible
	typedef enum logic [1:0] {
		K_CALC   = 2'd0,
		K_OPAQUE = 2'd1,
		K_CLEAR  = 2'd2,
		K_OUT    = 2'd3
	} kind_t;

	// 2^-(2^-(k+1)) in Q16, rounded to nearest
	function automatic logic [FRAC_W-1:0] exp2_neg(input logic [3:0] k);
		logic [FRAC_W-1:0] t;
		unique case (k)
			4'd0:  t = 16'd46341;
			4'd1:  t = 16'd55109;
			4'd2:  t = 16'd60097;
			4'd3:  t = 16'd62757;
			4'd4:  t = 16'd64132;
			4'd5:  t = 16'd64830;
			4'd6:  t = 16'd65182;
			4'd7:  t = 16'd65359;
			4'd8:  t = 16'd65447;
			4'd9:  t = 16'd65492;
			4'd10: t = 16'd65514;
			4'd11: t = 16'd65525;
			4'd12: t = 16'd65530;
			4'd13: t = 16'd65533;
			4'd14: t = 16'd65535;
			default: t = 16'd65535;
		endcase
		return t;
	endfunction

endpackage

### sv/gcsa_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module gcsa_sqrt_pipe #(
	parameter int SB_W = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [gcsa_pkg::RAD_W-1:0] rad,
	input  logic [SB_W-1:0]           in_sb,
	output logic                      out_vld,
	output logic [gcsa_pkg::ROOT_W-1:0] root,
	output logic [SB_W-1:0]           out_sb
);
	import gcsa_pkg::*;

	logic             vld_s [0:ROOT_W];
	logic [RAD_W-1:0] rem_s [0:ROOT_W];
	logic [RAD_W-1:0] res_s [0:ROOT_W];
	logic [SB_W-1:0]  sb_s  [0:ROOT_W];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = rad;
	assign res_s[0] = '0;
	assign sb_s[0]  = in_sb;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [RAD_W-1:0] BITV = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [RAD_W-1:0] trial;
		logic             take;

		assign trial = res_s[k] + BITV;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
				res_s[k+1] <= take ? (res_s[k] >> 1) + BITV : res_s[k] >> 1;
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign out_vld = vld_s[ROOT_W];
	assign root    = res_s[ROOT_W][ROOT_W-1:0];
	assign out_sb  = sb_s[ROOT_W];
endmodule

### sv/gcsa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module gcsa_div_pipe #(
	parameter int SB_W = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [gcsa_pkg::NUM_W-1:0] num,
	input  logic [gcsa_pkg::DEN_W-1:0] den,
	input  logic [SB_W-1:0]            in_sb,
	output logic                       out_vld,
	output logic [gcsa_pkg::Q_W-1:0]   quo,
	output logic [SB_W-1:0]            out_sb
);
	import gcsa_pkg::*;

	logic             vld_s [0:Q_W];
	logic [NUM_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   quo_s [0:Q_W];
	logic [SB_W-1:0]  sb_s  [0:Q_W];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = num;
	assign quo_s[0] = '0;
	assign sb_s[0]  = in_sb;

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [NUM_W-1:0] dsh;
		logic             ge;

		// quotient is known to fit Q_W bits, so the shifted divisor never overflows
		assign dsh = NUM_W'(den) << (Q_W - 1 - j);
		assign ge  = rem_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
				quo_s[j+1] <= {quo_s[j][Q_W-2:0], ge};
				sb_s[j+1]  <= sb_s[j];
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign quo     = quo_s[Q_W];
	assign out_sb  = sb_s[Q_W];
endmodule

### sv/gaussian_corner_shadow_alpha.sv
// Top level of the corner shadow alpha pipeline.
//
// Usage:
//   Input stream s_axis: one texel coordinate per item, tdata = {row, col}
//   with col in bits 9:0 and row in bits 19:10, bits 23:20 zero.
//   Output stream m_axis: one result per item, tdata = alpha (8 bit),
//   tuser = outside flag (texel at or beyond the texture edge, alpha 0).
//   Config channel cfg_*: index 0 writes tex_size, index 1 corner_radius;
//   always ready. Write only while the pipeline is empty.
// Throughput: one item per cycle unless stalled. Each stage is one register step,
//   such as a square, one square-root bit, one quotient bit or one table multiply;
//   the 19-bit root, the 19-bit quotient and the 16 exp2 steps set the depth.
// Stall: the whole pipeline advances on one enable, true when the output
//   register is empty or is being taken. While a result waits, all stages
//   hold and s_axis_tready is low; nothing is lost or repeated.
// Reset: clears all stage valid bits and returns tex_size to 64 and
//   corner_radius to 0. Results come out in input order.
module gaussian_corner_shadow_alpha #(
	parameter int MAX_SIZE = gcsa_pkg::MAX_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [9:0] col, [19:10] row, [23:20] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] alpha
	output logic        m_axis_tuser,   // [0] outside
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import gcsa_pkg::*;

	localparam int SB_W = $bits(kind_t);

	// ---------------- configuration ----------------
	logic [REG_W-1:0] tex_size_q, corner_radius_q;
	logic [REG_W-1:0] size_eff, span;
	logic [DEN_W-1:0] den_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_size_q      <= TEX_SIZE_RST;
			corner_radius_q <= CORNER_RADIUS_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEX_SIZE:      tex_size_q      <= cfg_data;
				REG_CORNER_RADIUS: corner_radius_q <= cfg_data;
			endcase
		end
	end

	// clamp oversized textures
	assign size_eff = (13'(tex_size_q) > 13'(MAX_SIZE)) ? REG_W'(MAX_SIZE) : tex_size_q;
	assign span     = size_eff - corner_radius_q;

	// divisor is only needed many stages later, so one register step is fine
	always_ff @(posedge clk) begin
		den_q <= DEN_W'(span) * DEN_W'(span);
	end

	// ---------------- pipeline control ----------------
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: classify, square coordinates ----------------
	logic [COORD_W-1:0]   col, row;
	kind_t                kind_in;
	logic                 vld_s1;
	kind_t                kind_s1;
	logic [2*COORD_W-1:0] col2_s1, row2_s1;

	assign col = s_axis_tdata[COORD_W-1:0];
	assign row = s_axis_tdata[2*COORD_W-1:COORD_W];

	always_comb begin
		if (size_eff <= REG_W'(1)) begin
			kind_in = (col == '0 && row == '0) ? K_OPAQUE : K_OUT;
		end else if (REG_W'(col) >= size_eff || REG_W'(row) >= size_eff) begin
			kind_in = K_OUT;
		end else begin
			kind_in = K_CALC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_in;
			col2_s1 <= (2*COORD_W)'(col) * (2*COORD_W)'(col);
			row2_s1 <= (2*COORD_W)'(row) * (2*COORD_W)'(row);
		end
	end

	// ---------------- stage 2: radicand ----------------
	logic             vld_s2;
	kind_t            kind_s2;
	logic [RAD_W-1:0] rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			rad_s2  <= (RAD_W'(col2_s1) + RAD_W'(row2_s1)) << 16;
		end
	end

	// ---------------- square root: distance in 11.8 ----------------
	logic              sq_vld;
	logic [ROOT_W-1:0] d8;
	logic [SB_W-1:0]   sq_sb;

	gcsa_sqrt_pipe #(.SB_W(SB_W)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.rad     (rad_s2),
		.in_sb   (SB_W'(kind_s2)),
		.out_vld (sq_vld),
		.root    (d8),
		.out_sb  (sq_sb)
	);

	// ---------------- stage 3: core test, clamp excess ----------------
	logic [ROOT_W-1:0] r8, s8, e8_raw;
	kind_t             kind_sq, kind_e;
	logic              vld_s3;
	kind_t             kind_s3;
	logic [ROOT_W-1:0] e8_s3;

	assign r8      = {corner_radius_q, 8'd0};
	assign s8      = {span, 8'd0};
	assign kind_sq = kind_t'(sq_sb);
	assign e8_raw  = d8 - r8;

	always_comb begin
		kind_e = kind_sq;
		if (kind_sq == K_CALC) begin
			if (d8 < r8) begin
				kind_e = K_OPAQUE;
			end else if (corner_radius_q >= size_eff) begin
				kind_e = K_CLEAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_e;
			e8_s3   <= (e8_raw > s8) ? s8 : e8_raw;
		end
	end

	// ---------------- stage 4: square the excess ----------------
	logic                vld_s4;
	kind_t               kind_s4;
	logic [2*ROOT_W-1:0] e8sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_s3;
			e8sq_s4 <= (2*ROOT_W)'(e8_s3) * (2*ROOT_W)'(e8_s3);
		end
	end

	// ---------------- stage 5: scale by log2(255), two partial products ----------------
	logic                vld_s5;
	kind_t               kind_s5;
	logic [2*ROOT_W-1:0] phi_s5, plo_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5 <= kind_s4;
			phi_s5  <= (2*ROOT_W)'(LOG2_255_Q16) * (2*ROOT_W)'(e8sq_s4[2*ROOT_W-1:ROOT_W]);
			plo_s5  <= (2*ROOT_W)'(LOG2_255_Q16) * (2*ROOT_W)'(e8sq_s4[ROOT_W-1:0]);
		end
	end

	// ---------------- stage 6: combine, drop the 2^16 of s8^2 ----------------
	localparam int PSUM_W = 3*ROOT_W;
	logic [PSUM_W-1:0] psum;
	logic              vld_s6;
	kind_t             kind_s6;
	logic [NUM_W-1:0]  num_s6;

	assign psum = (PSUM_W'(phi_s5) << ROOT_W) + PSUM_W'(plo_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s6 <= kind_s5;
			num_s6  <= psum[NUM_W+15:16];
		end
	end

	// ---------------- divide: exponent x in Q16 ----------------
	logic            dv_vld;
	logic [Q_W-1:0]  x_q16;
	logic [SB_W-1:0] dv_sb;

	gcsa_div_pipe #(.SB_W(SB_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.num     (num_s6),
		.den     (den_q),
		.in_sb   (SB_W'(kind_s6)),
		.out_vld (dv_vld),
		.quo     (x_q16),
		.out_sb  (dv_sb)
	);

	// ---------------- exp2 of the fraction, one table step per stage ----------------
	localparam int N_W = Q_W - FRAC_W;

	logic              ex_vld_s  [0:FRAC_W];
	kind_t             ex_kind_s [0:FRAC_W];
	logic [N_W-1:0]    ex_n_s    [0:FRAC_W];
	logic [FRAC_W-1:0] ex_f_s    [0:FRAC_W];
	logic [M_W-1:0]    ex_m_s    [0:FRAC_W];

	assign ex_vld_s[0]  = dv_vld;
	assign ex_kind_s[0] = kind_t'(dv_sb);
	assign ex_n_s[0]    = x_q16[Q_W-1:FRAC_W];
	assign ex_f_s[0]    = x_q16[FRAC_W-1:0];
	assign ex_m_s[0]    = M_W'(1) << FRAC_W;

	for (genvar k = 0; k < FRAC_W; k++) begin : g_exp
		localparam int P_W = M_W + FRAC_W;
		logic [P_W-1:0] prod;

		assign prod = P_W'(ex_m_s[k]) * P_W'(exp2_neg(4'(k))) + P_W'(1 << (FRAC_W - 1));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				ex_vld_s[k+1] <= ex_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ex_kind_s[k+1] <= ex_kind_s[k];
				ex_n_s[k+1]    <= ex_n_s[k];
				ex_f_s[k+1]    <= ex_f_s[k];
				ex_m_s[k+1]    <= ex_f_s[k][FRAC_W-1-k] ? prod[P_W-1:FRAC_W] : ex_m_s[k];
			end
		end
	end

	// ---------------- output register ----------------
	localparam int SC_W = M_W + ALPHA_W;
	logic [SC_W-1:0]    scaled;
	logic [ALPHA_W-1:0] alpha_calc, alpha_fin;
	kind_t              kind_fin;
	logic               vld_out;

	assign kind_fin   = ex_kind_s[FRAC_W];
	assign scaled     = SC_W'(ex_m_s[FRAC_W]) * SC_W'(255);
	assign alpha_calc = ALPHA_W'(scaled >> (FRAC_W + int'(ex_n_s[FRAC_W])));

	always_comb begin
		unique case (kind_fin)
			K_CALC:   alpha_fin = alpha_calc;
			K_OPAQUE: alpha_fin = '1;
			K_CLEAR:  alpha_fin = '0;
			K_OUT:    alpha_fin = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= ex_vld_s[FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= alpha_fin;
			m_axis_tuser <= (kind_fin == K_OUT);
		end
	end

	assign m_axis_tvalid = vld_out;
endmodule

### sv/gcsa_checker.sv
// Port-level checker for the corner shadow alpha block, with its bind.
module gcsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	// an outside texel never carries alpha
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
		else $error("outside result with nonzero alpha");

	// a waiting result freezes the input side
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// the register port never pushes back
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");
endmodule

bind gaussian_corner_shadow_alpha gcsa_checker u_gcsa_checker (.*);
